[src/usc_pkg.sv]
// ----------------------------------------------------------------------------
// usc_pkg: shared types and constants for the seconds-to-calendar converter
// Holds the controller states, divider operations, the command and status
// bundles between controller and datapath, and the calendar tables.
// ----------------------------------------------------------------------------
package usc_pkg;

  // Constant divisors of the four divides.
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] DAYS_PER_WEEK = 17'd7;

  // Scaled reciprocals of the odd part of each divisor. The quotient is
  // (operand * K) >> S, exact over the whole operand range of that divide.
  // Day:     (secs >> 7) * K >> 35, odd part 675, operand below 2^25.
  // Hour:    (rem >> 4) * K >> 21, odd part 225, operand below 2^13.
  // Minute:  (rem >> 2) * K >> 14, odd part 15, operand below 2^10.
  // Weekday: days * K >> 19, divisor 7, operand below 2^16.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR = 26'd9321;
  localparam logic [25:0] RECIP_MIN  = 26'd1093;
  localparam logic [25:0] RECIP_WDAY = 26'd74899;

  // Epoch: 1970-01-01 was a Thursday; 19 mod 4 is 3.
  localparam logic [6:0]  EPOCH_YY      = 7'd70;
  localparam logic [1:0]  EPOCH_CENT    = 2'd3;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
  localparam logic [6:0]  LAST_YY       = 7'd99;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_PUB
  } usc_state_t;

  typedef enum logic [1:0] {
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_WDAY
  } usc_op_t;

  typedef struct packed {
    logic    start;
    logic    div_step;
    logic    div_next;
    usc_op_t op;
    logic    year_step;
    logic    month_step;
    logic    publish;
  } usc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_done;
    logic month_done;
  } usc_stat_t;

  // Divisor of each divider operation.
  function automatic logic [16:0] div_divisor(input usc_op_t op);
    logic [16:0] d;
    case (op)
      OP_DAY:  d = SECS_PER_DAY;
      OP_HOUR: d = SECS_PER_HOUR;
      OP_MIN:  d = SECS_PER_MIN;
      OP_WDAY: d = DAYS_PER_WEEK;
      default: d = SECS_PER_DAY;
    endcase
    return d;
  endfunction

  // Length of a month (0 is January); February grows by one in a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[src/usc_dp.sv]
// ----------------------------------------------------------------------------
// usc_dp: datapath of the seconds-to-calendar converter
// Each divide by a constant is split: a reciprocal multiply forms the
// quotient, then the remainder is taken from the registered quotient. Four
// divides give days, hours, minutes, seconds and weekday. Year and month
// counters then peel whole years and months off the day count. Results sit
// in an output register that is separate from the working registers.
// ----------------------------------------------------------------------------
module usc_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  usc_pkg::usc_cmd_t  cmd,
  output usc_pkg::usc_stat_t stat,
  input  logic [31:0]     in_unix_seconds,
  output logic [4:0]      out_hour,
  output logic [5:0]      out_minute,
  output logic [5:0]      out_second,
  output logic [2:0]      out_weekday,
  output logic [4:0]      out_day_of_month,
  output logic [3:0]      out_month,
  output logic [6:0]      out_year_two_digit
);
  import usc_pkg::*;

  // Divide unit: operand of the current divide, its quotient, and a phase
  // flag that is high while the quotient is still to be formed.
  logic [31:0] num_r, num_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic        phase_r, phase_nxt;

  // Calendar working state.
  logic [15:0] days_r, days_nxt;
  logic [6:0]  yy_r, yy_nxt;
  logic [1:0]  cent_r, cent_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  weekday_r, weekday_nxt;

  // Output register.
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;
  logic [2:0]  out_weekday_r;
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [6:0]  out_yy_r;

  logic [24:0] recip_op;
  logic [25:0] recip_k;
  logic [50:0] recip_prod;
  logic [15:0] recip_quo;
  logic [16:0] divisor;
  logic [32:0] quo_times_d;
  logic [31:0] rem_full;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [15:0] wday_base;

  // Quotient by a scaled reciprocal. The power-of-two factor of the divisor
  // is shifted off first; the multiplier is 25 by 26 bits.
  always_comb begin
    case (cmd.op)
      OP_DAY: begin
        recip_op = num_r[31:7];
        recip_k  = RECIP_DAY;
      end
      OP_HOUR: begin
        recip_op = {12'd0, num_r[16:4]};
        recip_k  = RECIP_HOUR;
      end
      OP_MIN: begin
        recip_op = {15'd0, num_r[11:2]};
        recip_k  = RECIP_MIN;
      end
      OP_WDAY: begin
        recip_op = {9'd0, num_r[15:0]};
        recip_k  = RECIP_WDAY;
      end
      default: begin
        recip_op = num_r[31:7];
        recip_k  = RECIP_DAY;
      end
    endcase
    recip_prod = {26'd0, recip_op} * {25'd0, recip_k};
    case (cmd.op)
      OP_DAY:  recip_quo = recip_prod[50:35];
      OP_HOUR: recip_quo = recip_prod[36:21];
      OP_MIN:  recip_quo = recip_prod[29:14];
      OP_WDAY: recip_quo = recip_prod[34:19];
      default: recip_quo = recip_prod[50:35];
    endcase
  end

  // Remainder from the registered quotient.
  always_comb begin
    divisor     = div_divisor(cmd.op);
    quo_times_d = {17'd0, quo_r} * {16'd0, divisor};
    rem_full    = num_r - quo_times_d[31:0];
  end

  // Gregorian rule from the year within the century and the century mod 4.
  always_comb begin
    leap = (yy_r[1:0] == 2'd0) && ((yy_r != 7'd0) || (cent_r == 2'd0));
    ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    mlen = month_len(mon_r, leap);
    wday_base = days_r + EPOCH_WEEKDAY;
  end

  always_comb begin
    stat.div_done   = !phase_r;
    stat.year_done  = (days_r < {7'd0, ylen});
    stat.month_done = (days_r < {11'd0, mlen}) || (mon_r == LAST_MONTH);
  end

  // Next values of the working registers.
  always_comb begin
    num_nxt     = num_r;
    quo_nxt     = quo_r;
    phase_nxt   = phase_r;
    days_nxt    = days_r;
    yy_nxt      = yy_r;
    cent_nxt    = cent_r;
    mon_nxt     = mon_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    weekday_nxt = weekday_r;
    if (cmd.start) begin
      num_nxt   = in_unix_seconds;
      phase_nxt = 1'b1;
    end else if (cmd.div_step) begin
      quo_nxt   = recip_quo;
      phase_nxt = 1'b0;
    end else if (cmd.div_next) begin
      // Keep the result of the finished divide and load the next one.
      case (cmd.op)
        OP_DAY: begin
          days_nxt  = quo_r;
          num_nxt   = rem_full;
          phase_nxt = 1'b1;
        end
        OP_HOUR: begin
          hour_nxt  = quo_r[4:0];
          num_nxt   = rem_full;
          phase_nxt = 1'b1;
        end
        OP_MIN: begin
          minute_nxt = quo_r[5:0];
          second_nxt = rem_full[5:0];
          num_nxt    = {16'd0, wday_base};
          phase_nxt  = 1'b1;
        end
        OP_WDAY: begin
          weekday_nxt = rem_full[2:0];
          yy_nxt      = EPOCH_YY;
          cent_nxt    = EPOCH_CENT;
          mon_nxt     = 4'd0;
        end
        default: begin
          phase_nxt = 1'b0;
        end
      endcase
    end else if (cmd.year_step) begin
      days_nxt = days_r - {7'd0, ylen};
      if (yy_r == LAST_YY) begin
        yy_nxt   = 7'd0;
        cent_nxt = cent_r + 2'd1;
      end else begin
        yy_nxt = yy_r + 7'd1;
      end
    end else if (cmd.month_step) begin
      days_nxt = days_r - {11'd0, mlen};
      mon_nxt  = mon_r + 4'd1;
    end
  end

  // Phase flag is control-like and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    quo_r     <= quo_nxt;
    days_r    <= days_nxt;
    yy_r      <= yy_nxt;
    cent_r    <= cent_nxt;
    mon_r     <= mon_nxt;
    hour_r    <= hour_nxt;
    minute_r  <= minute_nxt;
    second_r  <= second_nxt;
    weekday_r <= weekday_nxt;
  end

  // Output register, loaded when the controller publishes a finished item.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_hour_r    <= hour_r;
      out_minute_r  <= minute_r;
      out_second_r  <= second_r;
      out_weekday_r <= weekday_r;
      out_day_r     <= days_r[4:0] + 5'd1;
      out_month_r   <= mon_r + 4'd1;
      out_yy_r      <= yy_r;
    end
  end

  assign out_hour           = out_hour_r;
  assign out_minute         = out_minute_r;
  assign out_second         = out_second_r;
  assign out_weekday        = out_weekday_r;
  assign out_day_of_month   = out_day_r;
  assign out_month          = out_month_r;
  assign out_year_two_digit = out_yy_r;

endmodule

[src/usc_ctrl.sv]
// ----------------------------------------------------------------------------
// usc_ctrl: controller of the seconds-to-calendar converter
// Sequences the four divides, the year loop and the month loop, then hands
// the finished item to the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module usc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  usc_pkg::usc_stat_t stat,
  output usc_pkg::usc_cmd_t  cmd
);
  import usc_pkg::*;

  usc_state_t state_r, state_nxt;
  usc_op_t    op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept;
  logic       out_free;

  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and divide operation.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
          op_nxt    = OP_DAY;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          case (op_r)
            OP_DAY:  op_nxt = OP_HOUR;
            OP_HOUR: op_nxt = OP_MIN;
            OP_MIN:  op_nxt = OP_WDAY;
            OP_WDAY: state_nxt = ST_YEAR;
            default: op_nxt = OP_DAY;
          endcase
        end
      end
      ST_YEAR: begin
        if (stat.year_done) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (stat.month_done) begin
          state_nxt = ST_PUB;
        end
      end
      ST_PUB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath and the output valid flag.
  always_comb begin
    cmd            = '0;
    cmd.op         = op_r;
    cmd.start      = in_accept;
    cmd.div_step   = (state_r == ST_DIV) && !stat.div_done;
    cmd.div_next   = (state_r == ST_DIV) && stat.div_done;
    cmd.year_step  = (state_r == ST_YEAR) && !stat.year_done;
    cmd.month_step = (state_r == ST_MONTH) && !stat.month_done;
    cmd.publish    = (state_r == ST_PUB) && out_free;
    out_valid_nxt  = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted item always starts with the day divide.
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_DIV) && (op_r == OP_DAY))
    else $error("accepted item did not start the divider");

  // The weekday divide is the last one before the year loop.
  a_wday_to_year: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_done && op_r == OP_WDAY) |=> (state_r == ST_YEAR))
    else $error("divide sequence did not hand over to the year loop");

  // A result appears only through the publish state.
  a_valid_from_pub: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_PUB))
    else $error("result valid raised outside the publish state");

  // A waiting result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || !out_stall))
    else $error("published over a stalled result");
`endif

endmodule

[src/unix_seconds_to_calendar.sv]
// Each item runs four constant divides, each a reciprocal multiply and then a
// remainder, then removes Y whole years (0..136) and M whole months (0..11).
// A new input is accepted only once the last item has been published.
// Years and months are removed one per cycle; a stalled result holds the input.
// Reset (rst_n low, synchronous) clears the controller and drops out_valid.
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar: seconds since 1970 to calendar date and time
// Splits a 32-bit second count into time of day, weekday, day of month,
// month and two-digit year with Gregorian leap years.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [6:0]  out_year_two_digit
);
  import usc_pkg::*;

  usc_cmd_t  cmd;
  usc_stat_t stat;

  // Sequencer.
  usc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Divider, calendar counters and output register.
  usc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_unix_seconds    (in_unix_seconds),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_weekday        (out_weekday),
    .out_day_of_month   (out_day_of_month),
    .out_month          (out_month),
    .out_year_two_digit (out_year_two_digit)
  );

endmodule
